>>> rtl/core/lfu_pkg.sv
package lfu_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int CAP_BITS       = 5;
   localparam int TIME_BITS      = 31;
   localparam int COUNT_BITS     = 16;
   localparam int STAMP_BITS     = 32;
   localparam logic [TIME_BITS-1:0] INT_MAX = {TIME_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_PUT    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] key;
      logic [31:0] value;
      logic signed [31:0] ttl_seconds;
      logic [30:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
      logic [4:0]  occupancy;
   } rsp_type;

endpackage

>>> rtl/core/lfu_cache_with_expiry_unit.sv
// Channel   Ports                      Direction  Handshake
// request   req_payload                in         start high while busy low
// response  rsp_payload                out        rsp_valid, one cycle
// csr       csr_write_en, csr_wr_data  in         written on any edge with enable
//
// Get, put and delete read every entry in turn through the single read port
// of the entry memory, whose output is registered; the walk is then seen to be
// done, the result is decided and written back, the occupancy is loaded, and
// the response strobes; the next request can be accepted at the edge that ends
// the strobe. Clear answers on the next cycle and never raises busy. Reset is
// synchronous and clears the valid bits, the occupancy count and the stamp
// counter, and returns the capacity register to sixteen. The receiver cannot
// stall; each response strobes for exactly one cycle.
module lfu_cache_with_expiry_unit #(
   parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lfu_pkg::req_type req_payload,
   output logic             rsp_valid,
   output lfu_pkg::rsp_type rsp_payload,
   input  logic             csr_write_en,
   input  logic [4:0]       csr_wr_data
);
   import lfu_pkg::*;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int EW = KEY_BITS + VALUE_BITS + TIME_BITS + COUNT_BITS + STAMP_BITS;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] data;
      logic [TIME_BITS-1:0]  expiry;
      logic [COUNT_BITS-1:0] count;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_RESP} state_type;

   // The memory holds the entry bodies; valid bits live in flip-flops because the
   // sweep drops expired entries during the walk and clear drops all at once.
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr, rd_addr;
   entry_type           wr_data, rd_data;

   lfu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data(wr_data), .rd_addr,
      .rd_data(rd_data)
   );

   state_type state_ff;
   logic [ENTRIES-1:0]    valid_ff;
   logic [CNT_BITS-1:0]   total_ff;
   logic [STAMP_BITS-1:0] seq_ff;
   logic [4:0]            cap_ff;
   req_type               req_ff;
   logic [TIME_BITS-1:0]  exp_ff;
   logic [IDX_BITS:0]     scan_ff;     // read address issued
   logic                  rd_vld_ff;   // rd_data belongs to rd_idx_ff
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic                  found_ff, vic_ok_ff;
   logic [IDX_BITS-1:0]   found_idx_ff, vic_idx_ff;
   entry_type             found_ent_ff;
   logic [COUNT_BITS-1:0] vic_cnt_ff;
   logic [STAMP_BITS-1:0] vic_age_ff;
   logic [KEY_BITS-1:0]   vic_key_ff;
   logic                  wr_en_ff;
   logic [IDX_BITS-1:0]   wr_addr_ff;
   entry_type             wr_data_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
   assign rd_addr = scan_ff[IDX_BITS-1:0];
   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   logic [KEY_BITS-1:0]   req_key;
   logic [VALUE_BITS-1:0] req_val;
   logic [CNT_BITS-1:0]   cap_eff;
   logic [31:0]           exp_sum;
   logic                  cur_live, cur_match, cur_better, is_sweep;
   logic [STAMP_BITS-1:0] cur_age;
   logic [ENTRIES-1:0]    one_hot_free;
   logic [IDX_BITS-1:0]   free_idx;
   logic                  free_any;
   logic [COUNT_BITS-1:0] bump_cnt;

   assign req_key = KEY_BITS'(req_ff.key);
   assign req_val = VALUE_BITS'(req_ff.value);
   assign exp_sum = {1'b0, req_payload.now_seconds} + {1'b0, req_payload.ttl_seconds[30:0]};
   assign is_sweep = (req_ff.opcode != OP_DELETE);
   assign cur_live = valid_ff[rd_idx_ff] &&
                     !(is_sweep && rd_data.expiry < req_ff.now_seconds);
   assign cur_match = cur_live && rd_data.key == req_key;
   assign cur_age   = seq_ff - rd_data.stamp;
   assign cur_better = !vic_ok_ff || rd_data.count < vic_cnt_ff ||
                       (rd_data.count == vic_cnt_ff && cur_age > vic_age_ff);
   assign bump_cnt = (found_ent_ff.count < COUNT_MAX) ? found_ent_ff.count + 1'b1
                                                       : found_ent_ff.count;

   always_comb begin
      if (cap_ff == 5'd0) cap_eff = CNT_BITS'(1);
      else if (32'(cap_ff) > ENTRIES) cap_eff = CNT_BITS'(ENTRIES);
      else cap_eff = CNT_BITS'(cap_ff);
   end

   // Lowest free slot, with the victim counted as free when full and not found.
   always_comb begin
      one_hot_free = ~valid_ff;
      if (vic_ok_ff && !found_ff && total_ff >= cap_eff) one_hot_free[vic_idx_ff] = 1'b1;
      free_any = |one_hot_free;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (one_hot_free[i]) free_idx = IDX_BITS'(i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         seq_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_ff      <= '0;
      end else begin
         if (csr_write_en) cap_ff <= csr_wr_data;
         unique case (state_ff)
            S_IDLE: begin
               wr_en_ff     <= 1'b0;
               rsp_valid_ff <= start && (req_payload.opcode == OP_CLEAR);
               if (start) begin
                  req_ff    <= req_payload;
                  found_ff  <= 1'b0;
                  vic_ok_ff <= 1'b0;
                  scan_ff   <= '0;
                  rd_vld_ff <= 1'b0;
                  if (req_payload.ttl_seconds[31] || exp_sum[31]) exp_ff <= INT_MAX;
                  else exp_ff <= exp_sum[TIME_BITS-1:0];
                  if (req_payload.opcode == OP_CLEAR) begin
                     valid_ff <= '0;
                     total_ff <= '0;
                     rsp_ff   <= '0;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               wr_en_ff     <= 1'b0;
               rsp_valid_ff <= 1'b0;
               // One entry read per cycle; the previous read is judged here.
               if (32'(scan_ff) < ENTRIES) begin
                  scan_ff   <= scan_ff + 1'b1;
                  rd_vld_ff <= 1'b1;
                  rd_idx_ff <= scan_ff[IDX_BITS-1:0];
               end else begin
                  rd_vld_ff <= 1'b0;
               end
               if (rd_vld_ff) begin
                  if (valid_ff[rd_idx_ff] && !cur_live) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                     total_ff <= total_ff - 1'b1;
                  end
                  if (cur_match) begin
                     found_ff     <= 1'b1;
                     found_idx_ff <= rd_idx_ff;
                     found_ent_ff <= rd_data;
                  end
                  if (cur_live && cur_better) begin
                     vic_ok_ff  <= 1'b1;
                     vic_idx_ff <= rd_idx_ff;
                     vic_cnt_ff <= rd_data.count;
                     vic_age_ff <= cur_age;
                     vic_key_ff <= rd_data.key;
                  end
               end
               if (!rd_vld_ff && 32'(scan_ff) >= ENTRIES) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               rsp_type             rsp_in;
               logic [ENTRIES-1:0]  valid_in;
               logic [CNT_BITS-1:0] total_in;
               rsp_in   = '0;
               valid_in = valid_ff;
               total_in = total_ff;
               rsp_valid_ff <= 1'b0;
               state_ff <= S_RESP;
               unique case (req_ff.opcode)
                  OP_GET: begin
                     wr_en_ff <= found_ff;
                     if (found_ff) begin
                        rsp_in.hit        = 1'b1;
                        rsp_in.read_value = 32'(found_ent_ff.data);
                        wr_addr_ff <= found_idx_ff;
                        wr_data_ff <= '{found_ent_ff.key, found_ent_ff.data,
                                        found_ent_ff.expiry, bump_cnt, seq_ff};
                        seq_ff <= seq_ff + 1'b1;
                     end
                  end
                  OP_PUT: begin
                     if (found_ff) begin
                        rsp_in.hit = 1'b1;
                        wr_en_ff   <= 1'b1;
                        wr_addr_ff <= found_idx_ff;
                        wr_data_ff <= '{found_ent_ff.key, req_val, exp_ff, bump_cnt, seq_ff};
                        seq_ff <= seq_ff + 1'b1;
                     end else begin
                        // The victim is dropped first so its slot can be reused.
                        if (total_ff >= cap_eff && vic_ok_ff) begin
                           rsp_in.evicted     = 1'b1;
                           rsp_in.evicted_key = 32'(vic_key_ff);
                           valid_in[vic_idx_ff] = 1'b0;
                           total_in = total_in - 1'b1;
                        end
                        if (free_any) begin
                           valid_in[free_idx] = 1'b1;
                           total_in = total_in + 1'b1;
                           seq_ff <= seq_ff + 1'b1;
                        end
                        wr_en_ff   <= free_any;
                        wr_addr_ff <= free_idx;
                        wr_data_ff <= '{req_key, req_val, exp_ff, COUNT_BITS'(1), seq_ff};
                     end
                  end
                  default: begin
                     wr_en_ff <= 1'b0;
                     if (found_ff) begin
                        rsp_in.hit = 1'b1;
                        valid_in[found_idx_ff] = 1'b0;
                        total_in = total_in - 1'b1;
                     end
                  end
               endcase
               rsp_ff   <= rsp_in;
               valid_ff <= valid_in;
               total_ff <= total_in;
            end
            S_RESP: begin
               wr_en_ff <= 1'b0;
               rsp_ff.occupancy <= 5'(total_ff);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               wr_en_ff     <= 1'b0;
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end
endmodule

>>> rtl/core/lfu_ram.sv
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
